FILE: src/kbq_pkg.sv
// Shared types, constants and codes of the keyboard event queue.
package kbq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 16;
  localparam int unsigned KEY_COUNT       = 128;
  localparam int unsigned KEY_W           = $clog2(KEY_COUNT);
  localparam int unsigned CODE_W          = 8;
  localparam int unsigned TIME_W          = 32;
  localparam int unsigned LOST_W          = 16;
  localparam int unsigned HELD_W          = 8;
  localparam int unsigned PADDR_W         = 3;
  localparam int unsigned PDATA_W         = 32;

  localparam logic [CODE_W-1:0] KEY_MASK     = 8'h7f;
  localparam logic [CODE_W-1:0] RELEASE_MASK = 8'h80;
  localparam logic [TIME_W-1:0] TIMER_MAX_RST = 32'hffff_ffff;
  localparam logic [LOST_W-1:0] LOST_MAX      = 16'hffff;

  localparam logic REG_TIMER_MAX = 1'b0;

  typedef enum logic [1:0] {
    CMD_EVENT       = 2'd0,
    CMD_POP         = 2'd1,
    CMD_RELEASE_ALL = 2'd2
  } cmd_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [TIME_W-1:0] stamp;
    logic [TIME_W-1:0] delta;
  } fifo_entry_t;

  typedef struct packed {
    logic             rd_en;
    logic [KEY_W-1:0] rd_addr;
    logic             wr_en;
    logic [KEY_W-1:0] wr_addr;
    logic             wr_held;
    logic             clear_all;
  } map_req_t;

endpackage

FILE: src/keyboard_event_queue.sv
// Keyboard event queue: held-key filter, timestamped event FIFO and loss counters.
// An item is taken when start is high and busy is low; busy then stays high for one cycle.
// Its result is strobed on result_valid_o in the cycle after that.
// No new item is taken while busy is high; the map and FIFO reads are registered.
// Reset zeroes map valid bits, rd_ptr, counters; wr_ptr to PTR_LAST, timer_max all ones.
// The result ports cannot be stalled by the receiver.
module keyboard_event_queue import kbq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  localparam int unsigned PTR_W      = $clog2(QUEUE_DEPTH),
  localparam int unsigned CNT_W      = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         command_i,
  input  logic [CODE_W-1:0]  scan_code_i,
  input  logic [TIME_W-1:0]  time_now_i,
  output logic               result_valid_o,
  output logic               event_queued_o,
  output logic               event_lost_o,
  output logic               pop_valid_o,
  output logic [CODE_W-1:0]  pop_scan_code_o,
  output logic [TIME_W-1:0]  pop_time_o,
  output logic [TIME_W-1:0]  pop_time_delta_o,
  output logic [CNT_W-1:0]   queued_count_o,
  output logic               queue_full_o,
  output logic               any_key_held_o,
  output logic [LOST_W-1:0]  lost_press_count_o,
  output logic [LOST_W-1:0]  lost_release_count_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  state_e state_q, state_d;
  logic   accept;

  logic [1:0]        cmd_q;
  logic [CODE_W-1:0] code_q;
  logic [TIME_W-1:0] now_q;

  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [HELD_W-1:0] held_total_q, held_total_d;
  logic [TIME_W-1:0] last_time_q, last_time_d;
  logic [LOST_W-1:0] lost_press_q, lost_press_d;
  logic [LOST_W-1:0] lost_rel_q, lost_rel_d;

  logic [TIME_W-1:0] timer_max;
  map_req_t          map_req;
  logic              key_held;
  fifo_entry_t       fifo_rdata;
  fifo_entry_t       fifo_wdata;
  logic              fifo_wr_en;
  logic [PTR_W-1:0]  wr_slot;

  logic              is_release;
  logic              change;
  logic              do_append;
  logic              do_pop;
  logic [TIME_W-1:0] delta;

  logic              queued_d, lost_d, pvalid_d;
  fifo_entry_t       pop_d;

  kbq_apb_regs u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .timer_max_o (timer_max)
  );

  kbq_held_map u_map (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (map_req),
    .held_o (key_held)
  );

  kbq_fifo_ram #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (rd_ptr_q),
    .rd_data_o (fifo_rdata),
    .wr_en_i   (fifo_wr_en),
    .wr_addr_i (wr_slot),
    .wr_data_i (fifo_wdata)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    busy = 1'b0;
    case (state_q)
      S_IDLE:  busy = 1'b0;
      S_EXEC:  busy = 1'b1;
      default: busy = 1'b0;
    endcase
  end

  assign accept = start & ~busy;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= command_i;
      code_q <= scan_code_i;
      now_q  <= time_now_i;
    end
  end

  assign is_release = (code_q & RELEASE_MASK) != '0;
  assign change     = busy && (cmd_e'(cmd_q) == CMD_EVENT) && (is_release == key_held);
  assign do_append  = change && (count_q != CNT_FULL);
  assign do_pop     = busy && (cmd_e'(cmd_q) == CMD_POP) && (count_q != '0);
  assign wr_slot    = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
  assign delta      = (last_time_q <= now_q) ? now_q - last_time_q
                                             : timer_max - last_time_q + 1'b1 + now_q;

  assign fifo_wr_en       = do_append;
  assign fifo_wdata.code  = code_q;
  assign fifo_wdata.stamp = now_q;
  assign fifo_wdata.delta = delta;

  always_comb begin
    map_req.rd_en     = accept;
    map_req.rd_addr   = KEY_W'(scan_code_i & KEY_MASK);
    map_req.wr_en     = change;
    map_req.wr_addr   = KEY_W'(code_q & KEY_MASK);
    map_req.wr_held   = ~is_release;
    map_req.clear_all = busy && (cmd_e'(cmd_q) == CMD_RELEASE_ALL);
  end

  always_comb begin
    rd_ptr_d     = rd_ptr_q;
    wr_ptr_d     = wr_ptr_q;
    count_d      = count_q;
    held_total_d = held_total_q;
    last_time_d  = last_time_q;
    lost_press_d = lost_press_q;
    lost_rel_d   = lost_rel_q;
    queued_d     = 1'b0;
    lost_d       = 1'b0;
    pvalid_d     = 1'b0;
    pop_d        = '0;
    if (busy) begin
      case (cmd_e'(cmd_q))
        CMD_EVENT: begin
          if (change) begin
            if (is_release) begin
              if (held_total_q != '0) begin
                held_total_d = held_total_q - 1'b1;
              end
            end else begin
              held_total_d = held_total_q + 1'b1;
            end
            if (do_append) begin
              queued_d    = 1'b1;
              wr_ptr_d    = wr_slot;
              count_d     = count_q + 1'b1;
              last_time_d = now_q;
            end else begin
              lost_d = 1'b1;
              if (is_release) begin
                if (lost_rel_q != LOST_MAX) begin
                  lost_rel_d = lost_rel_q + 1'b1;
                end
              end else if (lost_press_q != LOST_MAX) begin
                lost_press_d = lost_press_q + 1'b1;
              end
            end
          end
        end
        CMD_POP: begin
          if (do_pop) begin
            pvalid_d = 1'b1;
            pop_d    = fifo_rdata;
            rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
            count_d  = count_q - 1'b1;
          end
        end
        CMD_RELEASE_ALL: begin
          held_total_d = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      rd_ptr_q       <= '0;
      wr_ptr_q       <= PTR_LAST;
      count_q        <= '0;
      held_total_q   <= '0;
      last_time_q    <= '0;
      lost_press_q   <= '0;
      lost_rel_q     <= '0;
      result_valid_o <= 1'b0;
    end else begin
      state_q        <= state_d;
      rd_ptr_q       <= rd_ptr_d;
      wr_ptr_q       <= wr_ptr_d;
      count_q        <= count_d;
      held_total_q   <= held_total_d;
      last_time_q    <= last_time_d;
      lost_press_q   <= lost_press_d;
      lost_rel_q     <= lost_rel_d;
      result_valid_o <= busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy) begin
      event_queued_o       <= queued_d;
      event_lost_o         <= lost_d;
      pop_valid_o          <= pvalid_d;
      pop_scan_code_o      <= pop_d.code;
      pop_time_o           <= pop_d.stamp;
      pop_time_delta_o     <= pop_d.delta;
      queued_count_o       <= count_d;
      queue_full_o         <= (count_d == CNT_FULL);
      any_key_held_o       <= (held_total_d != '0);
      lost_press_count_o   <= lost_press_d;
      lost_release_count_o <= lost_rel_d;
    end
  end

  a_result_follows_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> result_valid_o)
    else $error("result strobe missing after an item was worked on");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result strobed while an item is still at work");

  a_queued_or_lost: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !(event_queued_o && event_lost_o))
    else $error("event reported both queued and lost");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_FULL)
    else $error("FIFO entry count exceeds the depth");

  a_lost_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy && lost_d) |-> (count_q == CNT_FULL))
    else $error("event dropped while the FIFO had room");

endmodule

FILE: src/kbq_held_map.sv
// Held-key map: a 128 by 1 memory with per-entry valid bits, so that clear_all clears every entry at once.
module kbq_held_map import kbq_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  map_req_t req_i,
  output logic     held_o
);

  logic                 held_mem [KEY_COUNT];
  logic [KEY_COUNT-1:0] valid_q;
  logic                 rd_data_q;
  logic                 rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      held_mem[req_i.wr_addr] <= req_i.wr_held;
    end
    if (req_i.rd_en) begin
      rd_data_q <= held_mem[req_i.rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (req_i.clear_all) begin
        valid_q <= '0;
      end else if (req_i.wr_en) begin
        valid_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_valid_q <= valid_q[req_i.rd_addr];
      end
    end
  end

  assign held_o = rd_valid_q & rd_data_q;

endmodule

FILE: src/kbq_fifo_ram.sv
// Event FIFO storage: one write port and one registered read port.
module kbq_fifo_ram import kbq_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  localparam int unsigned PTR_W      = $clog2(QUEUE_DEPTH)
) (
  input  logic        clk_i,
  input  logic        rd_en_i,
  input  logic [PTR_W-1:0] rd_addr_i,
  output fifo_entry_t rd_data_o,
  input  logic        wr_en_i,
  input  logic [PTR_W-1:0] wr_addr_i,
  input  fifo_entry_t wr_data_i
);

  fifo_entry_t mem [QUEUE_DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

FILE: src/kbq_apb_regs.sv
// APB configuration register holding the timer maximum.
module kbq_apb_regs import kbq_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output logic [TIME_W-1:0]  timer_max_o
);

  logic [TIME_W-1:0] timer_max_q;
  logic [TIME_W-1:0] timer_max_d;
  logic              wr_hit;

  assign pready = 1'b1;
  assign wr_hit = psel & penable & pwrite & pready & (paddr[2] == REG_TIMER_MAX);

  always_comb begin
    timer_max_d = timer_max_q;
    if (wr_hit) begin
      timer_max_d = pwdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timer_max_q <= TIMER_MAX_RST;
    end else begin
      timer_max_q <= timer_max_d;
    end
  end

  assign prdata      = (paddr[2] == REG_TIMER_MAX) ? timer_max_q : '0;
  assign timer_max_o = timer_max_q;

endmodule
